/* rtl/gcrgb_pkg.sv */
// shared types, constants and the log2 table for the gamma correction pipeline
package gcrgb_pkg;

    localparam int LogW  = 32;   // unsigned log value: 8 integer bits, 24 fraction bits
    localparam int LogFr = 24;

    typedef logic [LogW-1:0] t_log;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_GAMMA = 1'b0,
        REG_MAXV  = 1'b1
    } t_reg_idx;

    // fixed-point base-2 log of an 8-bit code, by repeated squaring of the mantissa
    function automatic t_log log2_fix(input logic [7:0] x);
        logic [7:0]  xv;
        int          n;
        logic [63:0] y;
        logic [63:0] acc;
        xv  = (x == 8'd0) ? 8'd1 : x;
        n   = 0;
        acc = '0;
        for (int k = 1; k < 8; k++) begin
            if ((xv >> k) != 8'd0) begin
                n = k;
            end
        end
        y   = 64'(xv) << (30 - n);
        acc = 64'(n);
        for (int i = 0; i < LogFr; i++) begin
            y   = (y * y) >> 30;
            acc = acc << 1;
            if (y >= (64'd1 << 31)) begin
                y   = y >> 1;
                acc = acc + 64'd1;
            end
        end
        return acc[LogW-1:0];
    endfunction

    // constant log table over all 8-bit codes
    typedef t_log t_log_tab [256];

    function automatic t_log_tab make_tab();
        t_log_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = log2_fix(8'(i));
        end
        return t;
    endfunction

    localparam t_log_tab LogTab = make_tab();

    // per-channel state between the target stage and the search stages
    typedef struct packed {
        logic        zero;
        logic        gz;
        logic [7:0]  r;
        logic signed [LogW+8:0] t;
    } t_chan;

endpackage

/* rtl/gcrgb_search.sv */
// one step of the binary search for the largest code whose log is within target
module gcrgb_search
    import gcrgb_pkg::*;
#(
    parameter int BIT = 7
) (
    input  t_chan i_c,
    output t_chan o_c
);
    logic [7:0] cand;
    logic signed [LogW+8:0] lc;

    // try setting this bit
    always_comb begin
        cand = i_c.r | (8'd1 << BIT);
        lc   = (LogW+9)'(signed'({1'b0, LogTab[cand]}));
        o_c  = i_c;
        if (lc <= i_c.t) begin
            o_c.r = cand;
        end
    end
endmodule

/* rtl/gcrgb_chan.sv */
// per-channel pipeline: log lookup, gamma product, target, then two search stages
module gcrgb_chan
    import gcrgb_pkg::*;
#(
    parameter int GammaFracBits = 12
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_c,
    input  logic [7:0]  i_m,
    input  logic [15:0] i_g,
    output logic [7:0]  o_r
);
    // stage 1: log difference
    logic               r_neg, r_zero, r_gz;
    logic [LogW-1:0]    r_mag;
    logic signed [LogW:0] r_lm;
    logic signed [LogW:0] n_diff;
    logic [15:0]        r_g;

    always_comb begin
        n_diff = signed'({1'b0, LogTab[i_c]}) - signed'({1'b0, LogTab[i_m]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= n_diff[LogW];
            r_mag  <= n_diff[LogW] ? LogW'(-n_diff) : n_diff[LogW-1:0];
            r_lm   <= signed'({1'b0, LogTab[i_m]});
            r_zero <= (i_c == 8'd0);
            r_gz   <= (i_g == 16'd0);
            r_g    <= i_g;
        end
    end

    // stage 2: gamma product
    logic [LogW+15:0]   r_p;
    logic               r2_neg, r2_zero, r2_gz;
    logic signed [LogW:0] r2_lm;
    logic [7:0]         r2_m;
    logic [7:0]         r_m1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= i_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= (LogW+16)'(r_g) * (LogW+16)'(r_mag);
            r2_neg  <= r_neg;
            r2_zero <= r_zero;
            r2_gz   <= r_gz;
            r2_lm   <= r_lm;
            r2_m    <= r_m1;
        end
    end

    // stage 3: target with directed rounding
    localparam logic [LogW+15:0] RndAdd = (LogW+16)'((64'd1 << GammaFracBits) - 64'd1);
    logic [LogW+15:0] n_sh;
    t_chan n_t, r_t;
    logic [7:0] r3_m;

    always_comb begin
        n_sh = r2_neg ? ((r_p + RndAdd) >> GammaFracBits) : (r_p >> GammaFracBits);
        n_t.zero = r2_zero;
        n_t.gz   = r2_gz;
        n_t.r    = 8'd0;
        n_t.t    = r2_neg ? ((LogW+9)'(r2_lm) - signed'((LogW+9)'(n_sh)))
                          : ((LogW+9)'(r2_lm) + signed'((LogW+9)'(n_sh)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= n_t;
            r3_m <= r2_m;
        end
    end

    // stage 4: upper four bits of the search
    t_chan s7, s6, s5, s4, r_s, s3, s2, s1, s0;
    logic [7:0] r4_m;
    gcrgb_search #(.BIT(7)) u_b7 (.i_c(r_t), .o_c(s7));
    gcrgb_search #(.BIT(6)) u_b6 (.i_c(s7),  .o_c(s6));
    gcrgb_search #(.BIT(5)) u_b5 (.i_c(s6),  .o_c(s5));
    gcrgb_search #(.BIT(4)) u_b4 (.i_c(s5),  .o_c(s4));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s  <= s4;
            r4_m <= r3_m;
        end
    end

    // stage 5: lower four bits and special cases
    gcrgb_search #(.BIT(3)) u_b3 (.i_c(r_s), .o_c(s3));
    gcrgb_search #(.BIT(2)) u_b2 (.i_c(s3),  .o_c(s2));
    gcrgb_search #(.BIT(1)) u_b1 (.i_c(s2),  .o_c(s1));
    gcrgb_search #(.BIT(0)) u_b0 (.i_c(s1),  .o_c(s0));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (s0.gz) begin
                o_r <= r4_m;
            end else if (s0.zero) begin
                o_r <= 8'd0;
            end else begin
                o_r <= s0.r;
            end
        end
    end
endmodule

/* rtl/gamma_correct_rgb_pixel.sv */
// top level of the streaming gamma correction pipeline with its register port
//
//  channel | direction | tdata (low bit up)                 | tuser
//  s_axis  | in        | red_in, green_in, blue_in           | last via tlast
//  m_axis  | out       | red_out, green_out, blue_out        | last via tlast
//  apb     | in/out    | gamma_q4_12 at 0x0, max_value at 0x4 | -
//
// five register stages: the log lookup, the gamma multiply, the target and two four-bit
// search stages; one pixel per clock while the output is not stalled
// the whole pipeline advances together and holds while the output is stalled
// reset clears the valid bits and loads gamma 1.0 and max value 255
module gamma_correct_rgb_pixel
    import gcrgb_pkg::*;
#(
    parameter int GAMMA_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int Depth = 5;

    logic [15:0] r_gamma;
    logic [7:0]  r_maxv;
    logic [7:0]  m_eff;
    logic        en;
    logic [Depth-1:0] r_vld;
    logic [Depth-1:0] r_last;
    t_reg_idx    idx;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= 16'd4096;
            r_maxv  <= 8'd255;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            case (idx)
                REG_GAMMA: r_gamma <= pwdata[15:0];
                REG_MAXV:  r_maxv  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (idx)
            REG_GAMMA: prdata = {16'd0, r_gamma};
            REG_MAXV:  prdata = {24'd0, r_maxv};
            default:   prdata = 32'd0;
        endcase
    end

    assign m_eff = (r_maxv == 8'd0) ? 8'd1 : r_maxv;

    // pipeline advances unless a valid result is stalled
    assign en            = !(r_vld[Depth-1] && !m_axis_tready);
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[Depth-2:0], s_axis_tlast};
        end
    end

    // three channel pipelines
    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        gcrgb_chan #(.GammaFracBits(GAMMA_FRAC_BITS)) u_chan (
            .i_clk (i_clk),
            .i_en  (en),
            .i_c   (s_axis_tdata[8*ch +: 8]),
            .i_m   (m_eff),
            .i_g   (r_gamma),
            .o_r   (m_axis_tdata[8*ch +: 8])
        );
    end

    assign m_axis_tvalid = r_vld[Depth-1];
    assign m_axis_tlast  = r_last[Depth-1];

    // stalled output holds its valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");
    // input taken only when pipeline moves
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
        else $error("ready mismatch");
    // accepted item shows up after the pipeline depth when never stalled
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result lost in pipeline");
endmodule
